// ===== rtl/core/rlhtp_pkg.sv =====
`timescale 1ns / 1ps

package rlhtp_pkg;

    // Fraction digits kept; later digits are dropped
    localparam int unsigned FRAC_DIGITS = 9;

    localparam int unsigned PREFIX_LEN = 7;
    localparam int unsigned TAG_LEN    = 4;

    localparam logic [15:0] WEEK_MAX  = 16'd65535;
    localparam logic [19:0] WHOLE_MAX = 20'd1048575;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_TAG        = 3'd1,
        PH_WEEK_FIRST = 3'd2,
        PH_WEEK       = 3'd3,
        PH_SEC_FIRST  = 3'd4,
        PH_SEC_INT    = 3'd5,
        PH_SEC_FRAC   = 3'd6
    } phase_t;

    typedef struct packed {
        logic        ok;
        logic [15:0] week;
        logic [19:0] seconds_whole;
        logic [29:0] seconds_frac_ns;
    } result_t;

    typedef struct packed {
        logic    emit;
        result_t res;
    } step_t;

    // Expected header character at a prefix position
    function automatic logic [7:0] head_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h23; // '#'
            3'd1:    c = 8'h52; // 'R'
            3'd2:    c = 8'h41; // 'A'
            3'd3:    c = 8'h4E; // 'N'
            3'd4:    c = 8'h47; // 'G'
            3'd5:    c = 8'h45; // 'E'
            3'd6:    c = 8'h41; // 'A'
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Expected time status character at a tag position
    function automatic logic [7:0] tag_char(input logic [1:0] idx);
        logic [7:0] c;
        unique case (idx)
            2'd0:    c = 8'h46; // 'F'
            2'd1:    c = 8'h49; // 'I'
            2'd2:    c = 8'h4E; // 'N'
            default: c = 8'h45; // 'E'
        endcase
        return c;
    endfunction

    // Nanosecond weight of the fraction digit at a position
    function automatic logic [26:0] frac_weight(input logic [3:0] pos);
        logic [26:0] w;
        unique case (pos)
            4'd0:    w = 27'd100000000;
            4'd1:    w = 27'd10000000;
            4'd2:    w = 27'd1000000;
            4'd3:    w = 27'd100000;
            4'd4:    w = 27'd10000;
            4'd5:    w = 27'd1000;
            4'd6:    w = 27'd100;
            4'd7:    w = 27'd10;
            4'd8:    w = 27'd1;
            default: w = 27'd0;
        endcase
        return w;
    endfunction

    // Append a decimal digit and clamp at cap
    function automatic logic [19:0] sat_push(input logic [19:0] acc,
                                             input logic [3:0]  d,
                                             input logic [19:0] cap);
        logic [23:0] v;
        v = {acc, 3'b000} + {3'b000, acc, 1'b0} + {20'd0, d};
        return (v > {4'd0, cap}) ? cap : v[19:0];
    endfunction

endpackage

// ===== rtl/core/range_log_header_time_parser_unit.sv =====
`timescale 1ns / 1ps

// Channel  Handshake             Payload
// in       in_valid / in_ready   byte_req[7:0], last
// out      out_valid / out_ready ok, week[15:0], seconds_whole[19:0],
//                                seconds_frac_ns[29:0]
//
// One byte per cycle unless a byte with a result finds the output register
// full: a byte waits in the input register while the line state updates, and
// its result is loaded into the output register as the byte is consumed.
// Reset clears the line state and both valid flags; no clearing pass.
// A byte that produces a result waits in the input register while the output
// register is still full; bytes without a result keep flowing.
module range_log_header_time_parser_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  byte_req,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        ok,
    output logic [15:0] week,
    output logic [19:0] seconds_whole,
    output logic [29:0] seconds_frac_ns
);
    import rlhtp_pkg::*;

    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_last_reg;
    logic       out_valid_reg;
    result_t    out_res_reg;

    step_t      step;
    logic       out_free;
    logic       s1_go;

    assign out_free = !out_valid_reg || out_ready;
    assign s1_go    = s1_valid_reg && (out_free || !step.emit);
    assign in_ready = !s1_valid_reg || s1_go;

    rlhtp_line_parser u_parser
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .step_en  (s1_go),
        .byte_req (s1_byte_reg),
        .last     (s1_last_reg),
        .step     (step)
    );

    // Capture the input transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_byte_reg <= byte_req;
            s1_last_reg <= last;
        end
    end

    // Load or drain the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_go && step.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && step.emit)
            out_res_reg <= step.res;
    end

    assign out_valid       = out_valid_reg;
    assign ok              = out_res_reg.ok;
    assign week            = out_res_reg.week;
    assign seconds_whole   = out_res_reg.seconds_whole;
    assign seconds_frac_ns = out_res_reg.seconds_frac_ns;

endmodule

// ===== rtl/core/rlhtp_line_parser.sv =====
`timescale 1ns / 1ps

module rlhtp_line_parser
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_en,
    input  logic [7:0]        byte_req,
    input  logic              last,
    output rlhtp_pkg::step_t  step
);
    import rlhtp_pkg::*;

    logic [2:0]  prefix_reg,  prefix_next;
    logic [2:0]  comma_reg,   comma_next;
    logic [2:0]  tag_reg,     tag_next;
    phase_t      phase_reg,   phase_next;
    logic [15:0] week_reg,    week_next;
    logic [19:0] whole_reg,   whole_next;
    logic [29:0] frac_reg,    frac_next;
    logic [3:0]  fcount_reg,  fcount_next;
    logic        decided_reg, decided_next;

    logic        is_digit;
    logic [3:0]  d;
    logic        emit;
    logic        emit_ok;
    logic [19:0] week_push;
    logic [30:0] frac_prod;
    logic [15:0] res_week;
    logic [19:0] res_whole;
    logic [29:0] res_frac;

    assign is_digit  = (byte_req >= CH_ZERO) && (byte_req <= CH_NINE);
    assign d         = byte_req[3:0];
    assign week_push = sat_push({4'd0, week_reg}, d, {4'd0, WEEK_MAX});
    assign frac_prod = {27'd0, d} * {4'd0, frac_weight(fcount_reg)};

    // Advance the line state by one byte
    always_comb
    begin
        prefix_next  = prefix_reg;
        comma_next   = comma_reg;
        tag_next     = tag_reg;
        phase_next   = phase_reg;
        week_next    = week_reg;
        whole_next   = whole_reg;
        frac_next    = frac_reg;
        fcount_next  = fcount_reg;
        decided_next = decided_reg;
        emit         = 1'b0;
        emit_ok      = 1'b0;

        if (!decided_reg)
        begin
            if (byte_req != CH_NUL)
            begin
                if (prefix_reg < 3'(PREFIX_LEN))
                begin
                    if (byte_req != head_char(prefix_reg))
                        emit = 1'b1;
                    else
                        prefix_next = prefix_reg + 3'd1;
                end
                else
                begin
                    unique case (phase_reg)
                        PH_TAG:
                        begin
                            if (tag_reg < 3'(TAG_LEN))
                            begin
                                if (byte_req != tag_char(tag_reg[1:0]))
                                    emit = 1'b1;
                                else
                                    tag_next = tag_reg + 3'd1;
                            end
                            else if (byte_req == CH_COMMA)
                            begin
                                comma_next = 3'd5;
                                phase_next = PH_WEEK_FIRST;
                            end
                            else if (byte_req == CH_SEMI || byte_req == CH_CR ||
                                     byte_req == CH_LF)
                                phase_next = PH_IDLE;
                            else
                                emit = 1'b1;
                        end
                        PH_WEEK_FIRST:
                        begin
                            if (!is_digit)
                                emit = 1'b1;
                            else
                            begin
                                week_next  = {12'd0, d};
                                phase_next = PH_WEEK;
                            end
                        end
                        PH_WEEK:
                        begin
                            if (is_digit)
                                week_next = week_push[15:0];
                            else if (byte_req == CH_COMMA)
                            begin
                                comma_next = 3'd6;
                                phase_next = PH_SEC_FIRST;
                            end
                            else
                                phase_next = PH_IDLE;
                        end
                        PH_SEC_FIRST:
                        begin
                            if (!is_digit)
                                emit = 1'b1;
                            else
                            begin
                                whole_next = {16'd0, d};
                                phase_next = PH_SEC_INT;
                            end
                        end
                        PH_SEC_INT:
                        begin
                            if (is_digit)
                                whole_next = sat_push(whole_reg, d, WHOLE_MAX);
                            else if (byte_req == CH_DOT)
                                phase_next = PH_SEC_FRAC;
                            else
                            begin
                                emit    = 1'b1;
                                emit_ok = 1'b1;
                            end
                        end
                        PH_SEC_FRAC:
                        begin
                            if (is_digit)
                            begin
                                if (fcount_reg < 4'(FRAC_DIGITS))
                                begin
                                    frac_next   = frac_reg + frac_prod[29:0];
                                    fcount_next = fcount_reg + 4'd1;
                                end
                            end
                            else
                            begin
                                emit    = 1'b1;
                                emit_ok = 1'b1;
                            end
                        end
                        default:
                        begin
                            if (byte_req == CH_COMMA)
                            begin
                                comma_next = (comma_reg < 3'd6) ? comma_reg + 3'd1
                                                                : comma_reg;
                                if (comma_next == 3'd4)
                                begin
                                    phase_next = PH_TAG;
                                    tag_next   = 3'd0;
                                end
                                else if (comma_next == 3'd5)
                                    phase_next = PH_WEEK_FIRST;
                                else if (comma_next == 3'd6)
                                    phase_next = PH_SEC_FIRST;
                            end
                        end
                    endcase
                end
            end

            // Close the line at end of text or on the final byte
            if (!emit && (byte_req == CH_NUL || last))
            begin
                emit    = 1'b1;
                emit_ok = (phase_next == PH_SEC_INT) || (phase_next == PH_SEC_FRAC);
            end

            if (emit)
                decided_next = 1'b1;
        end

        // Hold the parsed time before the line state is cleared
        res_week  = week_next;
        res_whole = whole_next;
        res_frac  = frac_next;

        // Start a fresh line after the final byte
        if (last)
        begin
            prefix_next  = 3'd0;
            comma_next   = 3'd0;
            tag_next     = 3'd0;
            phase_next   = PH_IDLE;
            week_next    = 16'd0;
            whole_next   = 20'd0;
            frac_next    = 30'd0;
            fcount_next  = 4'd0;
            decided_next = 1'b0;
        end
    end

    // Drive the result of this byte
    always_comb
    begin
        step.emit                = emit;
        step.res.ok              = emit_ok;
        step.res.week            = emit_ok ? res_week  : 16'd0;
        step.res.seconds_whole   = emit_ok ? res_whole : 20'd0;
        step.res.seconds_frac_ns = emit_ok ? res_frac  : 30'd0;
    end

    // Hold the line state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg  <= 3'd0;
            comma_reg   <= 3'd0;
            tag_reg     <= 3'd0;
            phase_reg   <= PH_IDLE;
            week_reg    <= 16'd0;
            whole_reg   <= 20'd0;
            frac_reg    <= 30'd0;
            fcount_reg  <= 4'd0;
            decided_reg <= 1'b0;
        end
        else if (step_en)
        begin
            prefix_reg  <= prefix_next;
            comma_reg   <= comma_next;
            tag_reg     <= tag_next;
            phase_reg   <= phase_next;
            week_reg    <= week_next;
            whole_reg   <= whole_next;
            frac_reg    <= frac_next;
            fcount_reg  <= fcount_next;
            decided_reg <= decided_next;
        end
    end

endmodule
